// ===== src/clsp_pkg.sv =====
`timescale 1ns / 1ps

package clsp_pkg;

   localparam int PREFIX_CHARS  = 8;
   localparam int COMMAND_CHARS = 8;
   localparam int PARAM_CHARS   = 8;
   localparam int VALUE_CHARS   = 8;
   localparam int MAX_COMMANDS  = 3;

   // fixed by the field widths
   localparam int TEXT_BYTES      = 8;
   localparam int NAME_SLOTS      = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [3:0] PREFIX_LIMIT  = 4'(PREFIX_CHARS);
   localparam logic [3:0] COMMAND_LIMIT = 4'(COMMAND_CHARS);
   localparam logic [3:0] PARAM_LIMIT   = 4'(PARAM_CHARS);
   localparam logic [3:0] VALUE_LIMIT   = 4'(VALUE_CHARS);

   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] COMMA_CHAR   = 8'h2c;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_CHAR      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COMMAND_COUNT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME0_TEXT    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME0_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME1_TEXT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME1_LENGTH  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME2_TEXT    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NAME2_LENGTH  = 3'd7;

   localparam logic [7:0] END_CHAR_RESET = 8'd10;

   typedef struct packed {
      logic        status;
      logic [63:0] prefix_text;
      logic [3:0]  prefix_count;
      logic [63:0] command_text;
      logic [3:0]  command_count_out;
      logic [63:0] param_text;
      logic [3:0]  param_count;
      logic [63:0] value_text;
      logic [3:0]  value_count;
   } rsp_payload_type;

endpackage

// ===== src/clsp_if.sv =====
`timescale 1ns / 1ps

interface clsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface clsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [63:0] prefix_text;
   logic [3:0]  prefix_count;
   logic [63:0] command_text;
   logic [3:0]  command_count_out;
   logic [63:0] param_text;
   logic [3:0]  param_count;
   logic [63:0] value_text;
   logic [3:0]  value_count;

   modport source (output valid, output status, output prefix_text, output prefix_count,
      output command_text, output command_count_out, output param_text,
      output param_count, output value_text, output value_count, input ready);
   modport sink (input valid, input status, input prefix_text, input prefix_count,
      input command_text, input command_count_out, input param_text,
      input param_count, input value_text, input value_count, output ready);
endinterface

// ===== src/command_line_stream_parser.sv =====
`timescale 1ns / 1ps

// Byte-stream parser for lines of the form [%prefix%]name[,param[,value]]. One byte is
// taken per clock; a byte equal to the end character produces one result (collected
// prefix, command, parameter and value text with their counts, plus a status that is
// 0 for a complete line) and is then parsed again as the first byte of the next line.
// Each byte is handled in the cycle it is transferred: the parser state registers and
// the three-entry command name compare sit in front of a result register backed by a
// one-entry skid register, so one byte per cycle is sustained and input stalls only
// when both result slots are full. Bytes that overflow a buffer, cannot continue a
// table name or are a bad splitter silently restart the line. The user must write
// configuration only while the stream is idle; the block itself does not enforce it.
module command_line_stream_parser
   import clsp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   clsp_req_if.sink                   req_stream,
   clsp_rsp_if.source                 rsp_stream,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_PREFIX = 3'd1;
   localparam logic [2:0] PH_CMD    = 3'd2;
   localparam logic [2:0] PH_SPLIT  = 3'd3;
   localparam logic [2:0] PH_PARAM  = 3'd4;
   localparam logic [2:0] PH_VALUE  = 3'd5;

   logic [7:0]  end_char_ff;
   logic [1:0]  command_count_ff;
   logic [63:0] name_text_ff [NAME_SLOTS];
   logic [3:0]  name_length_ff [NAME_SLOTS];

   logic [2:0] phase_ff, phase_in;
   logic [3:0] prefix_fill_ff, prefix_fill_in;
   logic [3:0] command_fill_ff, command_fill_in;
   logic [3:0] param_fill_ff, param_fill_in;
   logic [3:0] value_fill_ff, value_fill_in;
   logic [7:0] prefix_store_ff [TEXT_BYTES];
   logic [7:0] prefix_store_in [TEXT_BYTES];
   logic [7:0] command_store_ff [TEXT_BYTES];
   logic [7:0] command_store_in [TEXT_BYTES];
   logic [7:0] param_store_ff [TEXT_BYTES];
   logic [7:0] param_store_in [TEXT_BYTES];
   logic [7:0] value_store_ff [TEXT_BYTES];
   logic [7:0] value_store_in [TEXT_BYTES];

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   rsp_payload_type result;

   logic       accept;
   logic       hit;
   logic       produce;
   logic [7:0] b;
   logic [2:0] cur_phase;
   logic [3:0] cur_command_fill;
   logic [3:0] n_chars;
   logic [7:0] cand [TEXT_BYTES];
   logic [NAME_SLOTS-1:0] entry_on;
   logic [NAME_SLOTS-1:0] first_ok;
   logic [NAME_SLOTS-1:0] full_ok;
   logic [3:0]  eff_len [NAME_SLOTS];
   logic       any_first;
   logic       found;
   logic       to_split;

   function automatic logic [3:0] clamp_length(input logic [3:0] len);
      logic [3:0] r;
      r = len;
      if (len == 4'd0) r = 4'd1;
      else if (len > 4'd8) r = 4'd8;
      return r;
   endfunction

   function automatic logic [63:0] pack_text(input logic [7:0] chars [TEXT_BYTES],
                                             input logic [3:0] fill);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < TEXT_BYTES; i++) begin
         if (4'(i) < fill) v[8*i +: 8] = chars[i];
      end
      return v;
   endfunction

   assign accept  = req_stream.valid && req_stream.ready;
   assign b       = req_stream.in_byte;
   assign hit     = (b == end_char_ff);
   assign produce = accept && hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff      <= END_CHAR_RESET;
         command_count_ff <= 2'd1;
         for (int k = 0; k < NAME_SLOTS; k++) begin
            name_text_ff[k]   <= '0;
            name_length_ff[k] <= 4'd1;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_END_CHAR:      end_char_ff       <= csr_data[7:0];
            REG_COMMAND_COUNT: command_count_ff  <= csr_data[1:0];
            REG_NAME0_TEXT:    name_text_ff[0]   <= csr_data;
            REG_NAME0_LENGTH:  name_length_ff[0] <= csr_data[3:0];
            REG_NAME1_TEXT:    name_text_ff[1]   <= csr_data;
            REG_NAME1_LENGTH:  name_length_ff[1] <= csr_data[3:0];
            REG_NAME2_TEXT:    name_text_ff[2]   <= csr_data;
            REG_NAME2_LENGTH:  name_length_ff[2] <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // result of the current byte, taken from the state before it
   always_comb begin
      if (phase_ff == PH_SPLIT || phase_ff == PH_PARAM || phase_ff == PH_VALUE)
         result.status = 1'b0;
      else if (phase_ff == PH_START)
         result.status = (prefix_fill_ff == 4'd0);
      else
         result.status = 1'b1;
      result.prefix_text       = pack_text(prefix_store_ff, prefix_fill_ff);
      result.prefix_count      = prefix_fill_ff;
      result.command_text      = pack_text(command_store_ff, command_fill_ff);
      result.command_count_out = command_fill_ff;
      result.param_text        = pack_text(param_store_ff, param_fill_ff);
      result.param_count       = param_fill_ff;
      result.value_text        = pack_text(value_store_ff, value_fill_ff);
      result.value_count       = value_fill_ff;
   end

   // name table compare
   always_comb begin
      cur_command_fill = hit ? 4'd0 : command_fill_ff;
      n_chars = cur_command_fill + 4'd1;
      cand = command_store_ff;
      cand[cur_command_fill[2:0]] = b;
      found    = 1'b0;
      to_split = 1'b0;
      for (int k = 0; k < NAME_SLOTS; k++) begin
         eff_len[k]  = clamp_length(name_length_ff[k]);
         entry_on[k] = (k < MAX_COMMANDS) && (2'(k) < command_count_ff);
         first_ok[k] = entry_on[k] && (name_text_ff[k][7:0] == b);
         full_ok[k]  = entry_on[k] && (n_chars <= eff_len[k]);
         for (int i = 0; i < TEXT_BYTES; i++) begin
            if (4'(i) < n_chars && cand[i] != name_text_ff[k][8*i +: 8])
               full_ok[k] = 1'b0;
         end
      end
      any_first = |first_ok;
      // first matching entry decides whether the name is complete
      for (int k = 0; k < NAME_SLOTS; k++) begin
         if (!found && full_ok[k]) begin
            found    = 1'b1;
            to_split = (n_chars == eff_len[k]);
         end
      end
   end

   // parser next state
   always_comb begin
      cur_phase       = hit ? PH_START : phase_ff;
      phase_in        = cur_phase;
      prefix_fill_in  = hit ? 4'd0 : prefix_fill_ff;
      command_fill_in = cur_command_fill;
      param_fill_in   = hit ? 4'd0 : param_fill_ff;
      value_fill_in   = hit ? 4'd0 : value_fill_ff;
      prefix_store_in  = prefix_store_ff;
      command_store_in = command_store_ff;
      param_store_in   = param_store_ff;
      value_store_in   = value_store_ff;

      unique case (cur_phase)
         PH_START: begin
            if (b == PERCENT_CHAR) begin
               phase_in = PH_PREFIX;
            end else if (any_first) begin
               phase_in = PH_CMD;
               if (command_fill_in < COMMAND_LIMIT) begin
                  command_store_in[command_fill_in[2:0]] = b;
                  command_fill_in = command_fill_in + 4'd1;
               end
            end
         end
         PH_PREFIX: begin
            if (b == PERCENT_CHAR) begin
               phase_in = PH_START;
            end else if (prefix_fill_in >= PREFIX_LIMIT) begin
               phase_in = PH_START;
               prefix_fill_in = 4'd0;
               command_fill_in = 4'd0;
               param_fill_in = 4'd0;
               value_fill_in = 4'd0;
            end else begin
               prefix_store_in[prefix_fill_in[2:0]] = b;
               prefix_fill_in = prefix_fill_in + 4'd1;
            end
         end
         PH_CMD: begin
            if (command_fill_in >= COMMAND_LIMIT || !found) begin
               phase_in = PH_START;
               prefix_fill_in = 4'd0;
               command_fill_in = 4'd0;
               param_fill_in = 4'd0;
               value_fill_in = 4'd0;
            end else begin
               command_store_in = cand;
               command_fill_in = n_chars;
               if (to_split) phase_in = PH_SPLIT;
            end
         end
         PH_SPLIT: begin
            if (b == COMMA_CHAR) begin
               phase_in = PH_PARAM;
            end else begin
               phase_in = PH_START;
               prefix_fill_in = 4'd0;
               command_fill_in = 4'd0;
               param_fill_in = 4'd0;
               value_fill_in = 4'd0;
            end
         end
         PH_PARAM: begin
            if (param_fill_in >= PARAM_LIMIT) begin
               phase_in = PH_START;
               prefix_fill_in = 4'd0;
               command_fill_in = 4'd0;
               param_fill_in = 4'd0;
               value_fill_in = 4'd0;
            end else if (b == COMMA_CHAR) begin
               phase_in = PH_VALUE;
            end else begin
               param_store_in[param_fill_in[2:0]] = b;
               param_fill_in = param_fill_in + 4'd1;
            end
         end
         PH_VALUE: begin
            if (value_fill_in >= VALUE_LIMIT) begin
               phase_in = PH_START;
               prefix_fill_in = 4'd0;
               command_fill_in = 4'd0;
               param_fill_in = 4'd0;
               value_fill_in = 4'd0;
            end else begin
               value_store_in[value_fill_in[2:0]] = b;
               value_fill_in = value_fill_in + 4'd1;
            end
         end
         default: begin
            phase_in = PH_START;
            prefix_fill_in = 4'd0;
            command_fill_in = 4'd0;
            param_fill_in = 4'd0;
            value_fill_in = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         prefix_fill_ff  <= 4'd0;
         command_fill_ff <= 4'd0;
         param_fill_ff   <= 4'd0;
         value_fill_ff   <= 4'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         prefix_fill_ff  <= prefix_fill_in;
         command_fill_ff <= command_fill_in;
         param_fill_ff   <= param_fill_in;
         value_fill_ff   <= value_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prefix_store_ff  <= prefix_store_in;
         command_store_ff <= command_store_in;
         param_store_ff   <= param_store_in;
         value_store_ff   <= value_store_in;
      end
   end

   // result register with skid slot behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_stream.ready) begin
         if (produce) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (produce) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stream.ready = !skid_valid_ff;

   assign rsp_stream.valid             = out_valid_ff;
   assign rsp_stream.status            = out_ff.status;
   assign rsp_stream.prefix_text       = out_ff.prefix_text;
   assign rsp_stream.prefix_count      = out_ff.prefix_count;
   assign rsp_stream.command_text      = out_ff.command_text;
   assign rsp_stream.command_count_out = out_ff.command_count_out;
   assign rsp_stream.param_text        = out_ff.param_text;
   assign rsp_stream.param_count       = out_ff.param_count;
   assign rsp_stream.value_text        = out_ff.value_text;
   assign rsp_stream.value_count       = out_ff.value_count;

endmodule

// ===== src/clsp_checker.sv =====
`timescale 1ns / 1ps

module clsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       status,
   input logic [3:0] prefix_count,
   input logic [3:0] command_count_out,
   input logic [3:0] param_count,
   input logic [3:0] value_count
);

   // a pending result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // no result shows up without a byte transfer before it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !rsp_valid |=> !rsp_valid)
      else $error("result without input transfer");

   // incomplete lines never carry parameter or value text
   a_incomplete_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> param_count == 4'd0 && value_count == 4'd0)
      else $error("incomplete line with parameter or value");

   a_complete_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !status |-> prefix_count != 4'd0 || command_count_out != 4'd0)
      else $error("complete line with no prefix and no command");

endmodule

bind command_line_stream_parser clsp_checker u_clsp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_stream.valid),
   .req_ready         (req_stream.ready),
   .rsp_valid         (rsp_stream.valid),
   .rsp_ready         (rsp_stream.ready),
   .status            (rsp_stream.status),
   .prefix_count      (rsp_stream.prefix_count),
   .command_count_out (rsp_stream.command_count_out),
   .param_count       (rsp_stream.param_count),
   .value_count       (rsp_stream.value_count)
);
